FILE: sv/glbc_pkg.sv
// ----------------------------------------------------------------------------
// glbc_pkg
// shared types and constants of the local breakout classifier
// ----------------------------------------------------------------------------
package glbc_pkg;

   localparam int TableRowsDefault = 16;

   localparam logic [1:0] KIND_UPLINK   = 2'd0;
   localparam logic [1:0] KIND_DOWNLINK = 2'd1;
   localparam logic [1:0] KIND_SIGNAL   = 2'd2;
   localparam logic [1:0] KIND_RESERVED = 2'd3;

   localparam logic [1:0] CSR_BASE_STATION = 2'd0;
   localparam logic [1:0] CSR_BREAKOUT     = 2'd1;
   localparam logic [1:0] CSR_SUBNET       = 2'd2;

   localparam logic [3:0] ST_PASS          = 4'd0;
   localparam logic [3:0] ST_LOCAL         = 4'd1;
   localparam logic [3:0] ST_BREAKOUT_DROP = 4'd2;
   localparam logic [3:0] ST_DL_TUNNELED   = 4'd3;
   localparam logic [3:0] ST_DL_DROP       = 4'd4;
   localparam logic [3:0] ST_STORED        = 4'd5;
   localparam logic [3:0] ST_FULL          = 4'd6;
   localparam logic [3:0] ST_BS_STORED     = 4'd7;
   localparam logic [3:0] ST_UNKNOWN       = 4'd8;

   localparam logic [15:0] UPLINK_MIN_LEN = 16'd56;
   localparam logic [7:0]  VIHL_IPV4      = 8'h45;
   localparam logic [7:0]  PROTO_UDP      = 8'h11;
   localparam logic [7:0]  PROTO_ICMP     = 8'h01;
   localparam logic [7:0]  GTP_FLAGS_V1   = 8'h30;
   localparam logic [7:0]  GTP_TYPE_TPDU  = 8'hff;

   localparam logic [31:0] BREAKOUT_RESET = 32'd2887062628;
   localparam logic [23:0] SUBNET_RESET   = 24'd12626120;

   // operation decided by the front end
   typedef enum logic [2:0] {
      OP_PASS,
      OP_UPLINK,
      OP_DOWNLINK,
      OP_BS_SIGNAL,
      OP_CORE_SIGNAL
   } op_type;

   // back-end sequencer
   typedef enum logic [1:0] {
      BE_IDLE,
      BE_LOOKUP,
      BE_SEARCH2,
      BE_RESULT
   } be_state_type;

   typedef struct packed {
      op_type      op;
      logic        brk_hit;
      logic        sub_hit;
      logic [15:0] packet_length;
      logic [15:0] gtp_length;
      logic [31:0] tunnel_id;
      logic [31:0] inner_source;
      logic [31:0] inner_destination;
      logic [31:0] terminal_id;
   } cmd_type;

   typedef struct packed {
      logic [3:0]  status;
      logic        drop_verdict;
      logic        local_forward;
      logic [15:0] local_length;
      logic [31:0] out_tunnel_id;
      logic [15:0] out_tunnel_length;
      logic [4:0]  table_row;
   } rsp_type;

endpackage

FILE: sv/glbc_front.sv
// ----------------------------------------------------------------------------
// glbc_front
// header checks and rule decode of one input beat into a command
// ----------------------------------------------------------------------------
module glbc_front (
   input  logic               clock,
   input  logic               reset,
   input  logic [1:0]         kind,
   input  logic [15:0]        packet_length,
   input  logic [7:0]         outer_version_ihl,
   input  logic [7:0]         outer_protocol,
   input  logic [7:0]         gtp_flags,
   input  logic [7:0]         gtp_type,
   input  logic [15:0]        gtp_length,
   input  logic [31:0]        tunnel_id,
   input  logic [31:0]        inner_source,
   input  logic [31:0]        inner_destination,
   input  logic [31:0]        signal_source_ip,
   input  logic [31:0]        terminal_id,
   input  logic [31:0]        base_station_ip,
   input  logic [31:0]        breakout_ip,
   input  logic [23:0]        local_subnet_prefix,
   input  logic               push,
   output glbc_pkg::cmd_type  cmd,
   output logic               cmd_valid
);
   import glbc_pkg::*;

   cmd_type cmd_ff, cmd_in;
   logic    valid_ff;
   logic    hdr_ok;

   // uplink header checks
   assign hdr_ok = (packet_length >= UPLINK_MIN_LEN) && (outer_version_ihl == VIHL_IPV4) &&
                   ((outer_protocol == PROTO_UDP) || (outer_protocol == PROTO_ICMP)) &&
                   (gtp_flags == GTP_FLAGS_V1) && (gtp_type == GTP_TYPE_TPDU);

   // classify
   always_comb begin
      cmd_in                   = '0;
      cmd_in.packet_length     = packet_length;
      cmd_in.gtp_length        = gtp_length;
      cmd_in.tunnel_id         = tunnel_id;
      cmd_in.inner_source      = inner_source;
      cmd_in.inner_destination = inner_destination;
      cmd_in.terminal_id       = terminal_id;
      cmd_in.brk_hit           = inner_destination == breakout_ip;
      cmd_in.sub_hit           = inner_destination[31:8] == local_subnet_prefix;
      unique case (kind)
         KIND_UPLINK:   cmd_in.op = hdr_ok ? OP_UPLINK : OP_PASS;
         KIND_DOWNLINK: cmd_in.op = OP_DOWNLINK;
         KIND_SIGNAL:   cmd_in.op = (signal_source_ip == base_station_ip) ?
                                    OP_BS_SIGNAL : OP_CORE_SIGNAL;
         default:       cmd_in.op = OP_PASS;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push) cmd_ff <= cmd_in;
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= push;
   end

   assign cmd       = cmd_ff;
   assign cmd_valid = valid_ff;
endmodule

FILE: sv/glbc_cmd_fifo.sv
// ----------------------------------------------------------------------------
// glbc_cmd_fifo
// short command queue between classifier and table engine
// ----------------------------------------------------------------------------
module glbc_cmd_fifo (
   input  logic               clock,
   input  logic               reset,
   input  logic               wr_en,
   input  glbc_pkg::cmd_type  wr_data,
   input  logic               rd_en,
   output glbc_pkg::cmd_type  rd_data,
   output logic               not_empty,
   output logic [2:0]         level
);
   import glbc_pkg::*;

   cmd_type    slot_ff [4];
   logic [1:0] wp_ff, rp_ff;
   logic [2:0] cnt_ff;

   always_ff @(posedge clock) begin
      if (wr_en) slot_ff[wp_ff] <= wr_data;
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (wr_en) wp_ff <= wp_ff + 2'd1;
         if (rd_en) rp_ff <= rp_ff + 2'd1;
         cnt_ff <= cnt_ff + {2'b0, wr_en} - {2'b0, rd_en};
      end
   end

   assign rd_data   = slot_ff[rp_ff];
   assign not_empty = cnt_ff != 3'd0;
   assign level     = cnt_ff;
endmodule

FILE: sv/glbc_back.sv
// ----------------------------------------------------------------------------
// glbc_back
// terminal table engine: parallel row compare, update and response queue
// ----------------------------------------------------------------------------
module glbc_back #(
   parameter int TableRows = glbc_pkg::TableRowsDefault
) (
   input  logic               clock,
   input  logic               reset,
   input  glbc_pkg::cmd_type  cmd,
   input  logic               cmd_ready,
   output logic               cmd_take,
   output glbc_pkg::rsp_type  rsp,
   output logic               rsp_valid,
   input  logic               rsp_pop,
   output logic [1:0]         rsp_level
);
   import glbc_pkg::*;

   localparam int IdxW = (TableRows > 1) ? $clog2(TableRows) : 1;
   localparam int CntW = $clog2(TableRows + 1);
   localparam logic [CntW-1:0] FULL_COUNT = CntW'(TableRows);

   logic [31:0] core_ff    [TableRows];
   logic [31:0] station_ff [TableRows];
   logic [31:0] learned_ff [TableRows];
   logic [31:0] signal_ff  [TableRows];
   logic [CntW-1:0] count_ff;

   be_state_type state_ff, state_in;
   cmd_type      cur_ff;

   // per-row match vectors, registered
   logic [TableRows-1:0] m_core_ff, m_learn_ff, m_sig_ff, m_learn2_ff;
   logic [TableRows-1:0] m_core, m_learn, m_sig, m_learn2;
   logic [IdxW-1:0]      core_idx, learn_idx, sig_idx;
   logic                 core_any, learn_any, sig_any;
   logic [31:0]          learn_post [TableRows];

   // response queue
   rsp_type    rq_ff [2];
   logic       rq_wp_ff, rq_rp_ff;
   logic [1:0] rq_cnt_ff;
   rsp_type    res;
   logic       res_push;

   // row compares in the lookup cycle
   always_comb begin
      for (int i = 0; i < TableRows; i++) begin
         m_core[i]  = (CntW'(i) < count_ff) && (core_ff[i] == cur_ff.tunnel_id);
         m_learn[i] = (CntW'(i) < count_ff) && (learned_ff[i] == cur_ff.inner_destination);
         m_sig[i]   = (CntW'(i) < count_ff) && (signal_ff[i] == cur_ff.terminal_id);
      end
   end

   // priority encoders on the registered vectors
   always_comb begin
      core_idx = '0; learn_idx = '0; sig_idx = '0;
      for (int i = TableRows - 1; i >= 0; i--) begin
         if (m_core_ff[i])  core_idx  = IdxW'(i);
         if (m_learn_ff[i]) learn_idx = IdxW'(i);
         if (m_sig_ff[i])   sig_idx   = IdxW'(i);
      end
      core_any  = |m_core_ff;
      learn_any = |m_learn_ff;
      sig_any   = |m_sig_ff;
   end

   // second address search, after the learned address is taken
   always_comb begin
      for (int i = 0; i < TableRows; i++) begin
         learn_post[i] = (core_any && (core_idx == IdxW'(i))) ?
                         cur_ff.inner_source : learned_ff[i];
         m_learn2[i]   = (CntW'(i) < count_ff) &&
                         (learn_post[i] == cur_ff.inner_destination);
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BE_IDLE:    if (cmd_ready && rq_cnt_ff != 2'd2) state_in = BE_LOOKUP;
         BE_LOOKUP:  state_in = BE_SEARCH2;
         BE_SEARCH2: state_in = BE_RESULT;
         BE_RESULT:  state_in = BE_IDLE;
         default:    state_in = BE_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      cmd_take = (state_ff == BE_IDLE) && cmd_ready && (rq_cnt_ff != 2'd2);
      res_push = state_ff == BE_RESULT;
   end

   // result of the current command
   always_comb begin
      logic fwd, drop, apply;
      res           = '0;
      res.table_row = 5'(TableRows);
      fwd  = 1'b0;
      drop = 1'b0;
      apply = 1'b0;
      unique case (cur_ff.op)
         OP_UPLINK: begin
            if (cur_ff.brk_hit) begin
               drop = 1'b1;
               if (core_any) begin
                  fwd   = 1'b1;
                  apply = 1'b1;
               end
            end
            if (cur_ff.sub_hit && core_any) begin
               apply = 1'b1;
               if (|m_learn2_ff) begin
                  drop = 1'b1;
                  fwd  = 1'b1;
               end
            end
            res.drop_verdict  = drop;
            res.local_forward = fwd;
            res.status        = fwd ? ST_LOCAL : (drop ? ST_BREAKOUT_DROP : ST_PASS);
            res.local_length  = fwd ? cur_ff.gtp_length : 16'd0;
            if (apply) res.table_row = 5'(core_idx);
         end
         OP_DOWNLINK: begin
            if (learn_any) begin
               res.status            = ST_DL_TUNNELED;
               res.out_tunnel_id     = station_ff[learn_idx];
               res.out_tunnel_length = cur_ff.packet_length;
               res.table_row         = 5'(learn_idx);
            end else begin
               res.status = ST_DL_DROP;
            end
         end
         OP_BS_SIGNAL: begin
            if (sig_any) begin
               res.status    = ST_BS_STORED;
               res.table_row = 5'(sig_idx);
            end else begin
               res.status = ST_UNKNOWN;
            end
         end
         OP_CORE_SIGNAL: begin
            if (core_any) begin
               res.status    = ST_STORED;
               res.table_row = 5'(core_idx);
            end else if (count_ff == FULL_COUNT) begin
               res.status = ST_FULL;
            end else begin
               res.status    = ST_STORED;
               res.table_row = 5'(count_ff);
            end
         end
         default: res.status = ST_PASS;
      endcase
   end

   // sequencer, match registers and table update
   always_ff @(posedge clock) begin
      if (cmd_take) cur_ff <= cmd;
      if (state_ff == BE_LOOKUP) begin
         m_core_ff  <= m_core;
         m_learn_ff <= m_learn;
         m_sig_ff   <= m_sig;
      end
      if (state_ff == BE_SEARCH2) m_learn2_ff <= m_learn2;
      if (state_ff == BE_RESULT) begin
         unique case (cur_ff.op)
            OP_UPLINK:
               if ((cur_ff.brk_hit || cur_ff.sub_hit) && core_any)
                  learned_ff[core_idx] <= cur_ff.inner_source;
            OP_BS_SIGNAL:
               if (sig_any) station_ff[sig_idx] <= cur_ff.tunnel_id;
            OP_CORE_SIGNAL: begin
               logic [IdxW-1:0] wr;
               wr = core_any ? core_idx : count_ff[IdxW-1:0];
               if (core_any || count_ff != FULL_COUNT) begin
                  core_ff[wr]    <= cur_ff.tunnel_id;
                  station_ff[wr] <= '0;
                  learned_ff[wr] <= '0;
                  signal_ff[wr]  <= cur_ff.terminal_id;
               end
            end
            default: ;
         endcase
      end
      if (reset) begin
         state_ff <= BE_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == BE_RESULT && cur_ff.op == OP_CORE_SIGNAL && !core_any &&
             count_ff != FULL_COUNT)
            count_ff <= count_ff + CntW'(1);
      end
   end

   // response queue
   always_ff @(posedge clock) begin
      if (res_push) rq_ff[rq_wp_ff] <= res;
      if (reset) begin
         rq_wp_ff  <= 1'b0;
         rq_rp_ff  <= 1'b0;
         rq_cnt_ff <= '0;
      end else begin
         if (res_push) rq_wp_ff <= ~rq_wp_ff;
         if (rsp_pop && rq_cnt_ff != 2'd0) rq_rp_ff <= ~rq_rp_ff;
         rq_cnt_ff <= rq_cnt_ff + {1'b0, res_push} -
                      {1'b0, (rsp_pop && rq_cnt_ff != 2'd0)};
      end
   end

   assign rsp       = rq_ff[rq_rp_ff];
   assign rsp_valid = rq_cnt_ff != 2'd0;
   assign rsp_level = rq_cnt_ff;
endmodule

FILE: sv/gtp_local_breakout_classifier_top.sv
// ----------------------------------------------------------------------------
// gtp_local_breakout_classifier_top
// terminal table classifier for a tunneled local breakout point
// ----------------------------------------------------------------------------
// path: front register, command queue, table engine lookup, second address search
//   after learning, update in the result state, response queue; the engine takes a
//   new command only after update and while the response queue has room
// reset: synchronous; clears row count, queue pointers, sequencer state and the
//   configuration registers to their defaults, table contents are undefined until written
module gtp_local_breakout_classifier_top #(
   parameter int TableRows = glbc_pkg::TableRowsDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data,
   input  logic        push,
   output logic        full,
   input  logic [1:0]  req_kind,
   input  logic [15:0] req_packet_length,
   input  logic [7:0]  req_outer_version_ihl,
   input  logic [7:0]  req_outer_protocol,
   input  logic [7:0]  req_gtp_flags,
   input  logic [7:0]  req_gtp_type,
   input  logic [15:0] req_gtp_length,
   input  logic [31:0] req_tunnel_id,
   input  logic [31:0] req_inner_source,
   input  logic [31:0] req_inner_destination,
   input  logic [31:0] req_signal_source_ip,
   input  logic [31:0] req_terminal_id,
   output logic        empty,
   input  logic        pop,
   output logic [3:0]  rsp_status,
   output logic        rsp_drop_verdict,
   output logic        rsp_local_forward,
   output logic [15:0] rsp_local_length,
   output logic [31:0] rsp_out_tunnel_id,
   output logic [15:0] rsp_out_tunnel_length,
   output logic [4:0]  rsp_table_row
);
   import glbc_pkg::*;

   logic [31:0] bs_ip_ff, brk_ip_ff;
   logic [23:0] subnet_ff;
   cmd_type     f_cmd, q_cmd;
   logic        f_valid, q_ne, q_take, accept;
   logic [2:0]  q_level;
   rsp_type     rsp;
   logic        rsp_valid;
   logic [1:0]  rsp_level;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         bs_ip_ff  <= '0;
         brk_ip_ff <= BREAKOUT_RESET;
         subnet_ff <= SUBNET_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_BASE_STATION: bs_ip_ff  <= csr_data;
            CSR_BREAKOUT:     brk_ip_ff <= csr_data;
            CSR_SUBNET:       subnet_ff <= csr_data[23:0];
            default: ;
         endcase
      end
   end

   // room for the beat in the front register plus the queue
   assign full   = ({1'b0, q_level} + {3'b0, f_valid}) >= 4'd3;
   assign accept = push && !full;

   glbc_front u_front (
      .clock, .reset,
      .kind(req_kind), .packet_length(req_packet_length),
      .outer_version_ihl(req_outer_version_ihl), .outer_protocol(req_outer_protocol),
      .gtp_flags(req_gtp_flags), .gtp_type(req_gtp_type), .gtp_length(req_gtp_length),
      .tunnel_id(req_tunnel_id), .inner_source(req_inner_source),
      .inner_destination(req_inner_destination),
      .signal_source_ip(req_signal_source_ip), .terminal_id(req_terminal_id),
      .base_station_ip(bs_ip_ff), .breakout_ip(brk_ip_ff),
      .local_subnet_prefix(subnet_ff),
      .push(accept), .cmd(f_cmd), .cmd_valid(f_valid)
   );

   glbc_cmd_fifo u_fifo (
      .clock, .reset,
      .wr_en(f_valid), .wr_data(f_cmd),
      .rd_en(q_take), .rd_data(q_cmd), .not_empty(q_ne), .level(q_level)
   );

   glbc_back #(.TableRows(TableRows)) u_back (
      .clock, .reset,
      .cmd(q_cmd), .cmd_ready(q_ne), .cmd_take(q_take),
      .rsp(rsp), .rsp_valid(rsp_valid), .rsp_pop(pop), .rsp_level(rsp_level)
   );

   assign empty                 = !rsp_valid || (rsp_level == 2'd0);
   assign rsp_status            = rsp.status;
   assign rsp_drop_verdict      = rsp.drop_verdict;
   assign rsp_local_forward     = rsp.local_forward;
   assign rsp_local_length      = rsp.local_length;
   assign rsp_out_tunnel_id     = rsp.out_tunnel_id;
   assign rsp_out_tunnel_length = rsp.out_tunnel_length;
   assign rsp_table_row         = rsp.table_row;
endmodule
